### rtl/gjps_pkg.sv
// shared types, codes and tables of the grid jump point successor unit
package gjps_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic       blocked;
    logic [1:0] goal_slot;
    logic       has_parent;
    logic [7:0] parent_x;
    logic [7:0] parent_y;
  } gjps_item_t;

  typedef struct packed {
    logic [7:0] succ_x;
    logic [7:0] succ_y;
    logic       succ_valid;
    logic       last;
  } gjps_result_t;

  localparam logic [1:0] MODE_CELL   = 2'd0;
  localparam logic [1:0] MODE_GOAL   = 2'd1;
  localparam logic [1:0] MODE_EXPAND = 2'd2;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_GOALS = 2'd2;

  localparam logic [8:0] COLS_RESET  = 9'd256;
  localparam logic [8:0] ROWS_RESET  = 9'd256;
  localparam logic [2:0] GOALS_RESET = 3'd1;

  localparam logic signed [1:0] D_NEG  = 2'sb11;
  localparam logic signed [1:0] D_ZERO = 2'sb00;
  localparam logic signed [1:0] D_POS  = 2'sb01;

  // 3x3 window probe order, row by row
  localparam logic signed [1:0] PROBE_OX [9] = '{D_NEG, D_ZERO, D_POS, D_NEG, D_ZERO, D_POS,
                                                 D_NEG, D_ZERO, D_POS};
  localparam logic signed [1:0] PROBE_OY [9] = '{D_NEG, D_NEG, D_NEG, D_ZERO, D_ZERO, D_ZERO,
                                                 D_POS, D_POS, D_POS};
  // neighbor order without a parent
  localparam logic signed [1:0] DIR_DX [8] = '{D_ZERO, D_POS, D_ZERO, D_NEG, D_POS, D_POS,
                                               D_NEG, D_NEG};
  localparam logic signed [1:0] DIR_DY [8] = '{D_POS, D_ZERO, D_NEG, D_ZERO, D_POS, D_NEG,
                                               D_NEG, D_POS};

  typedef struct packed {
    logic [8:0] grid_cols;
    logic [8:0] grid_rows;
    logic [2:0] goal_count;
  } gjps_cfg_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } gjps_dir_t;

  typedef enum logic [2:0] {
    W_HOLD  = 3'd0,
    W_CAND  = 3'd1,
    W_RADV  = 3'd2,
    W_ADV   = 3'd3,
    W_HLINE = 3'd4,
    W_VLINE = 3'd5,
    W_DADV  = 3'd6
  } gjps_wop_t;

  typedef struct packed {
    logic      clr;
    logic      load;
    logic      fetch;
    gjps_wop_t wop;
    logic      cand_load;
    logic      cand_next;
    logic      keep;
    logic      push;
    logic      fin;
  } gjps_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic fetch_done;
    logic center_blk;
    logic at_goal;
    logic line_forced;
    logic diag_forced;
    logic ray_diag;
    logic cand_end;
    logic cand_zero;
    logic have_pend;
    logic out_free;
  } gjps_status_t;

  function automatic logic [3:0] nbr_idx(input logic signed [1:0] ox,
                                         input logic signed [1:0] oy);
    nbr_idx = 4'((int'(oy) + 1) * 3 + int'(ox) + 1);
  endfunction

endpackage

### rtl/gjps_regs.sv
// configuration register file on the apb port
module gjps_regs
  import gjps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output gjps_cfg_t   cfg
);

  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_cols  <= COLS_RESET;
      cfg.grid_rows  <= ROWS_RESET;
      cfg.goal_count <= GOALS_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_COLS:  cfg.grid_cols  <= pwdata[8:0];
        REG_ROWS:  cfg.grid_rows  <= pwdata[8:0];
        REG_GOALS: cfg.goal_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLS:  prdata = {23'd0, cfg.grid_cols};
      REG_ROWS:  prdata = {23'd0, cfg.grid_rows};
      REG_GOALS: prdata = {29'd0, cfg.goal_count};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

### rtl/gjps_ctrl.sv
// sequencing state machine of the successor search
module gjps_ctrl
  import gjps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic [1:0]   item_mode,
  output logic         item_ready,
  input  gjps_status_t st,
  output gjps_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_NODE_WAIT = 9'b000000100,
    S_CAND      = 9'b000001000,
    S_RAY_WAIT  = 9'b000010000,
    S_H_WAIT    = 9'b000100000,
    S_V_WAIT    = 9'b001000000,
    S_FOUND     = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wop    = W_HOLD;
    item_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (item_mode == MODE_EXPAND) begin
            cmd.fetch  = 1'b1;
            state_next = S_NODE_WAIT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_NODE_WAIT: begin
        if (st.fetch_done) begin
          cmd.cand_load = 1'b1;
          state_next    = S_CAND;
        end
      end
      S_CAND: begin
        if (st.cand_end) begin
          state_next = S_FINISH;
        end else if (st.cand_zero) begin
          cmd.cand_next = 1'b1;
        end else begin
          cmd.wop    = W_CAND;
          cmd.fetch  = 1'b1;
          state_next = S_RAY_WAIT;
        end
      end
      S_RAY_WAIT: begin
        if (st.fetch_done) begin
          if (st.center_blk) begin
            cmd.cand_next = 1'b1;
            state_next    = S_CAND;
          end else if (st.at_goal) begin
            state_next = S_FOUND;
          end else if (st.ray_diag) begin
            if (st.diag_forced) begin
              state_next = S_FOUND;
            end else begin
              cmd.wop    = W_HLINE;
              cmd.fetch  = 1'b1;
              state_next = S_H_WAIT;
            end
          end else if (st.line_forced) begin
            state_next = S_FOUND;
          end else begin
            cmd.wop   = W_RADV;
            cmd.fetch = 1'b1;
          end
        end
      end
      S_H_WAIT: begin
        if (st.fetch_done) begin
          if (st.center_blk) begin
            cmd.wop    = W_VLINE;
            cmd.fetch  = 1'b1;
            state_next = S_V_WAIT;
          end else if (st.at_goal || st.line_forced) begin
            state_next = S_FOUND;
          end else begin
            cmd.wop   = W_ADV;
            cmd.fetch = 1'b1;
          end
        end
      end
      S_V_WAIT: begin
        if (st.fetch_done) begin
          if (st.center_blk) begin
            cmd.wop    = W_DADV;
            cmd.fetch  = 1'b1;
            state_next = S_RAY_WAIT;
          end else if (st.at_goal || st.line_forced) begin
            state_next = S_FOUND;
          end else begin
            cmd.wop   = W_ADV;
            cmd.fetch = 1'b1;
          end
        end
      end
      S_FOUND: begin
        if (!st.have_pend) begin
          cmd.keep      = 1'b1;
          cmd.cand_next = 1'b1;
          state_next    = S_CAND;
        end else if (st.out_free) begin
          cmd.push      = 1'b1;
          cmd.cand_next = 1'b1;
          state_next    = S_CAND;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_mode != MODE_EXPAND |=> state == S_FINISH)
    else $error("write item did not go to acknowledge");

  a_first_found: assert property (@(posedge clk) disable iff (rst)
    state == S_FOUND && !st.have_pend |=> state == S_CAND)
    else $error("first jump point not parked");

  a_ray_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_RAY_WAIT && !st.fetch_done |=> state == S_RAY_WAIT)
    else $error("ray step left before window fetch");

endmodule

### rtl/gjps_dp.sv
// datapath: blocked map, goal table, window fetch, ray walker and result register
module gjps_dp
  import gjps_pkg::*;
#(
  parameter int GRID_DIM  = 256,
  parameter int MAX_GOALS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  gjps_cfg_t    cfg,
  input  gjps_item_t   item,
  input  gjps_cmd_t    cmd,
  output gjps_status_t st,
  output logic         result_valid,
  input  logic         result_ready,
  output gjps_result_t result
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ($clog2(GRID_DIM + 1) > 9) ? $clog2(GRID_DIM + 1) : 9;
  localparam int CW    = XW + 2;

  function automatic logic signed [CW-1:0] sx(input logic signed [1:0] v);
    sx = CW'(v);
  endfunction

  function automatic logic nb(input logic [8:0] v, input logic signed [1:0] ox,
                              input logic signed [1:0] oy);
    nb = v[nbr_idx(ox, oy)];
  endfunction

  logic mem [DEPTH];
  logic            rdata;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            wdata;
  logic            we;
  logic [AW-1:0]   clr_cnt;

  logic signed [CW-1:0] cx, cy, wx, wy, dgx, dgy, px, py, cols_eff, rows_eff;
  logic [7:0]  parx, pary;
  logic        has_par;
  gjps_dir_t   d, ldir;
  logic [15:0] goal_tab [MAX_GOALS];

  logic        f_busy, f_done, q_vld, q_oob, p_oob;
  logic [3:0]  f_cnt, q_idx;
  logic [8:0]  nbr;

  gjps_dir_t   cand [8];
  gjps_dir_t   lst_c [8];
  logic [3:0]  n_c, nc, ci;
  logic signed [1:0] pdx, pdy;

  logic [7:0]  pend_x, pend_y;
  logic        have_pend, goal_hit, lf, df;
  int          goal_lim;

  // map storage
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = 1'b0;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.load && item.mode == MODE_CELL &&
                 int'(item.cell_x) < GRID_DIM && int'(item.cell_y) < GRID_DIM) begin
      we    = 1'b1;
      waddr = AW'(int'(item.cell_y) * GRID_DIM + int'(item.cell_x));
      wdata = item.blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // probe address of the current window cell
  always_comb begin
    cols_eff = (int'(cfg.grid_cols) > GRID_DIM) ? CW'(GRID_DIM) : CW'(cfg.grid_cols);
    rows_eff = (int'(cfg.grid_rows) > GRID_DIM) ? CW'(GRID_DIM) : CW'(cfg.grid_rows);
    px    = wx + sx(PROBE_OX[f_cnt]);
    py    = wy + sx(PROBE_OY[f_cnt]);
    p_oob = (px < 0) || (py < 0) || (px >= cols_eff) || (py >= rows_eff);
    raddr = p_oob ? '0 : AW'(int'(py) * GRID_DIM + int'(px));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_busy <= 1'b0;
      f_done <= 1'b0;
      q_vld  <= 1'b0;
    end else begin
      q_vld <= f_busy;
      if (q_vld && q_idx == 4'd8) f_done <= 1'b1;
      if (cmd.fetch) begin
        f_busy <= 1'b1;
        f_done <= 1'b0;
      end else if (f_busy && f_cnt == 4'd8) begin
        f_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) f_cnt <= '0;
    else if (f_busy) f_cnt <= f_cnt + 4'd1;
    q_idx <= f_cnt;
    q_oob <= p_oob;
    if (q_vld) nbr[q_idx] <= q_oob | rdata;
  end

  // goal table
  always_ff @(posedge clk) begin
    for (int g = 0; g < MAX_GOALS; g++) begin
      if (cmd.load && item.mode == MODE_GOAL && int'(item.goal_slot) == g)
        goal_tab[g] <= {item.cell_y, item.cell_x};
    end
  end

  always_comb begin
    goal_lim = (int'(cfg.goal_count) > MAX_GOALS) ? MAX_GOALS : int'(cfg.goal_count);
    goal_hit = 1'b0;
    for (int g = 0; g < MAX_GOALS; g++) begin
      if (g < goal_lim && int'(wx) == int'(goal_tab[g][7:0]) &&
          int'(wy) == int'(goal_tab[g][15:8]))
        goal_hit = 1'b1;
    end
  end

  // walker
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx      <= CW'(item.cell_x);
      cy      <= CW'(item.cell_y);
      wx      <= CW'(item.cell_x);
      wy      <= CW'(item.cell_y);
      parx    <= item.parent_x;
      pary    <= item.parent_y;
      has_par <= item.has_parent;
    end else begin
      case (cmd.wop)
        W_CAND: begin
          d    <= cand[ci[2:0]];
          ldir <= cand[ci[2:0]];
          wx   <= cx + sx(cand[ci[2:0]].dx);
          wy   <= cy + sx(cand[ci[2:0]].dy);
          dgx  <= cx + sx(cand[ci[2:0]].dx);
          dgy  <= cy + sx(cand[ci[2:0]].dy);
        end
        W_RADV: begin
          wx  <= wx + sx(ldir.dx);
          wy  <= wy + sx(ldir.dy);
          dgx <= wx + sx(ldir.dx);
          dgy <= wy + sx(ldir.dy);
        end
        W_ADV: begin
          wx <= wx + sx(ldir.dx);
          wy <= wy + sx(ldir.dy);
        end
        W_HLINE: begin
          ldir <= '{dx: d.dx, dy: D_ZERO};
          wx   <= dgx + sx(d.dx);
          wy   <= dgy;
        end
        W_VLINE: begin
          ldir <= '{dx: D_ZERO, dy: d.dy};
          wx   <= dgx;
          wy   <= dgy + sx(d.dy);
        end
        W_DADV: begin
          ldir <= d;
          wx   <= dgx + sx(d.dx);
          wy   <= dgy + sx(d.dy);
          dgx  <= dgx + sx(d.dx);
          dgy  <= dgy + sx(d.dy);
        end
        default: ;
      endcase
    end
  end

  // pruned neighbor list
  always_comb begin
    pdx = (int'(cx) > int'(parx)) ? D_POS : ((int'(cx) < int'(parx)) ? D_NEG : D_ZERO);
    pdy = (int'(cy) > int'(pary)) ? D_POS : ((int'(cy) < int'(pary)) ? D_NEG : D_ZERO);
    n_c = '0;
    for (int i = 0; i < 8; i++) lst_c[i] = '0;
    if (!has_par) begin
      for (int i = 0; i < 8; i++) begin
        if (!nb(nbr, DIR_DX[i], DIR_DY[i])) begin
          lst_c[n_c[2:0]] = '{dx: DIR_DX[i], dy: DIR_DY[i]};
          n_c = n_c + 4'd1;
        end
      end
    end else if (pdx != D_ZERO && pdy != D_ZERO) begin
      if (!nb(nbr, D_ZERO, pdy)) begin
        lst_c[n_c[2:0]] = '{dx: D_ZERO, dy: pdy};
        n_c = n_c + 4'd1;
      end
      if (!nb(nbr, pdx, D_ZERO)) begin
        lst_c[n_c[2:0]] = '{dx: pdx, dy: D_ZERO};
        n_c = n_c + 4'd1;
      end
      if (!nb(nbr, pdx, pdy)) begin
        lst_c[n_c[2:0]] = '{dx: pdx, dy: pdy};
        n_c = n_c + 4'd1;
      end
      if (nb(nbr, -pdx, D_ZERO) && !nb(nbr, -pdx, pdy)) begin
        lst_c[n_c[2:0]] = '{dx: -pdx, dy: pdy};
        n_c = n_c + 4'd1;
      end
      if (nb(nbr, D_ZERO, -pdy) && !nb(nbr, pdx, -pdy)) begin
        lst_c[n_c[2:0]] = '{dx: pdx, dy: -pdy};
        n_c = n_c + 4'd1;
      end
    end else if (pdx == D_ZERO) begin
      if (!nb(nbr, D_ZERO, pdy)) begin
        lst_c[n_c[2:0]] = '{dx: D_ZERO, dy: pdy};
        n_c = n_c + 4'd1;
        if (nb(nbr, D_NEG, D_ZERO)) begin
          lst_c[n_c[2:0]] = '{dx: D_NEG, dy: pdy};
          n_c = n_c + 4'd1;
        end
        if (nb(nbr, D_POS, D_ZERO)) begin
          lst_c[n_c[2:0]] = '{dx: D_POS, dy: pdy};
          n_c = n_c + 4'd1;
        end
      end
    end else begin
      if (!nb(nbr, pdx, D_ZERO)) begin
        lst_c[n_c[2:0]] = '{dx: pdx, dy: D_ZERO};
        n_c = n_c + 4'd1;
        if (nb(nbr, D_ZERO, D_NEG)) begin
          lst_c[n_c[2:0]] = '{dx: pdx, dy: D_NEG};
          n_c = n_c + 4'd1;
        end
        if (nb(nbr, D_ZERO, D_POS)) begin
          lst_c[n_c[2:0]] = '{dx: pdx, dy: D_POS};
          n_c = n_c + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      for (int i = 0; i < 8; i++) cand[i] <= lst_c[i];
      nc <= n_c;
      ci <= '0;
    end else if (cmd.cand_next) begin
      ci <= ci + 4'd1;
    end
  end

  // forced neighbor tests on the walker window
  always_comb begin
    if (ldir.dx == D_ZERO)
      lf = (nb(nbr, D_NEG, D_ZERO) && !nb(nbr, D_NEG, ldir.dy)) ||
           (nb(nbr, D_POS, D_ZERO) && !nb(nbr, D_POS, ldir.dy));
    else
      lf = (nb(nbr, D_ZERO, D_POS) && !nb(nbr, ldir.dx, D_POS)) ||
           (nb(nbr, D_ZERO, D_NEG) && !nb(nbr, ldir.dx, D_NEG));
    df = (!nb(nbr, -ldir.dx, ldir.dy) && nb(nbr, -ldir.dx, D_ZERO)) ||
         (!nb(nbr, ldir.dx, -ldir.dy) && nb(nbr, D_ZERO, -ldir.dy));
  end

  // parked jump point and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_pend    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load || cmd.fin) have_pend <= 1'b0;
      else if (cmd.keep) have_pend <= 1'b1;
      if (cmd.push || cmd.fin) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep || cmd.push) begin
      pend_x <= 8'(dgx);
      pend_y <= 8'(dgy);
    end
    if (cmd.push) begin
      result <= '{succ_x: pend_x, succ_y: pend_y, succ_valid: 1'b1, last: 1'b0};
    end else if (cmd.fin) begin
      if (have_pend)
        result <= '{succ_x: pend_x, succ_y: pend_y, succ_valid: 1'b1, last: 1'b1};
      else
        result <= '{succ_x: 8'd0, succ_y: 8'd0, succ_valid: 1'b0, last: 1'b1};
    end
  end

  always_comb begin
    st.clr_last    = (clr_cnt == AW'(DEPTH - 1));
    st.fetch_done  = f_done;
    st.center_blk  = nb(nbr, D_ZERO, D_ZERO);
    st.at_goal     = goal_hit;
    st.line_forced = lf;
    st.diag_forced = df;
    st.ray_diag    = (ldir.dx != D_ZERO) && (ldir.dy != D_ZERO);
    st.cand_end    = (ci == nc);
    st.cand_zero   = (cand[ci[2:0]] == '0);
    st.have_pend   = have_pend;
    st.out_free    = !result_valid || result_ready;
  end

endmodule

### rtl/grid_jump_point_successors_unit.sv
// top level of the grid jump point successor unit
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_ready    gjps_item_t
//  result    out        result_valid / result_ready gjps_result_t
//  config    in         apb psel/penable/pwrite    grid_cols, grid_rows, goal_count
//
// cell and goal writes give one acknowledge result
// an expand reads a 3x3 map window for the node and every ray step,
// through the single map read port, so time grows with ray length and map contents
// after reset a clearing pass writes all GRID_DIM*GRID_DIM map cells before the first item
// a full result register stalls the search only when a further result must leave
module grid_jump_point_successors_unit
  import gjps_pkg::*;
#(
  parameter int GRID_DIM  = 256,
  parameter int MAX_GOALS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  gjps_item_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output gjps_result_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  gjps_cfg_t    cfg;
  gjps_cmd_t    cmd;
  gjps_status_t st;

  gjps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gjps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  gjps_dp #(
    .GRID_DIM  (GRID_DIM),
    .MAX_GOALS (MAX_GOALS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
